### hw/rtl/amdq_pkg.sv
package amdq_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_VERTICES_DEF = 32;
    localparam int WEIGHT_BITS_DEF  = 16;

    // Neighbor items per query are capped at MAX_RESULTS-1
    localparam int MAX_RESULTS = 33;
    localparam int NB_W        = $clog2(MAX_RESULTS);

    // Fixed field widths
    localparam int VTX_W  = 5;
    localparam int VCNT_W = 6;
    localparam int DEG_W  = 6;
    localparam int ET_W   = 11;
    localparam int WGT_W  = 16;
    localparam int ET_MAX = (1 << ET_W) - 1;

    // Command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Result kinds
    localparam logic KIND_NEIGHBOR = 1'b0;
    localparam logic KIND_SUMMARY  = 1'b1;

    // Configuration register indexes
    localparam int          CFG_IDX_W    = 1;
    localparam logic [0:0]  CFG_DIRECTED = 1'b0;
    localparam logic [0:0]  CFG_VCOUNT   = 1'b1;
    localparam logic [VCNT_W-1:0] VCOUNT_RST = 6'd32;

    typedef struct packed {
        logic                    command;
        logic [VTX_W-1:0]        from_vertex;
        logic [VTX_W-1:0]        to_vertex;
        logic signed [WGT_W-1:0] edge_weight;
    } t_in_item;

    typedef struct packed {
        logic              item_kind;
        logic [VTX_W-1:0]  neighbor;
        logic [DEG_W-1:0]  out_degree;
        logic [DEG_W-1:0]  in_degree;
        logic [ET_W-1:0]   edge_total;
        logic              bad_vertex;
        logic              last_item;
    } t_out_item;

    // Controller -> datapath
    typedef struct packed {
        logic load;     // capture incoming item
        logic clr_we;   // clearing sweep write
        logic add_rd;   // read old entries for an add
        logic wr_fwd;   // write (from,to)
        logic wr_rev;   // write mirrored (to,from)
        logic scan_rd;  // read row/column entry j
        logic sum;      // load summary into output register
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_query;
        logic add_ok;
        logic query_ok;
        logic mirror;
        logic scan_last;
    } t_dp_stat;

endpackage

### hw/rtl/amdq_ram.sv
module amdq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

### hw/rtl/amdq_ctrl.sv
module amdq_ctrl #(
    parameter int AW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  amdq_pkg::t_dp_stat i_stat,
    output amdq_pkg::t_dp_cmd  o_cmd,
    output logic [AW-1:0]     o_idx
);
    import amdq_pkg::*;

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_DISPATCH = 3'd2;
    localparam logic [2:0] ST_ADD_RD   = 3'd3;
    localparam logic [2:0] ST_WR_FWD   = 3'd4;
    localparam logic [2:0] ST_WR_REV   = 3'd5;
    localparam logic [2:0] ST_SCAN     = 3'd6;
    localparam logic [2:0] ST_SUM      = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_flush, n_flush;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_flush = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                n_idx        = r_idx + AW'(1);
                if (r_idx == {AW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_idx = '0;
                if (i_stat.is_query) begin
                    n_state = i_stat.query_ok ? ST_SCAN : ST_SUM;
                end else begin
                    n_state = i_stat.add_ok ? ST_ADD_RD : ST_IDLE;
                end
            end
            ST_ADD_RD: begin
                o_cmd.add_rd = 1'b1;
                n_state      = ST_WR_FWD;
            end
            ST_WR_FWD: begin
                o_cmd.wr_fwd = 1'b1;
                n_state      = i_stat.mirror ? ST_WR_REV : ST_IDLE;
            end
            ST_WR_REV: begin
                o_cmd.wr_rev = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_SCAN: begin
                // r_flush: wait for the last read to land before the summary
                if (r_flush) begin
                    n_state = ST_SUM;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_idx         = r_idx + AW'(1);
                    n_flush       = i_stat.scan_last;
                end
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_flush <= n_flush;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_idx  = r_idx;

    a_sum_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |=> !o_busy)
        else $error("summary not followed by idle");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_DISPATCH))
        else $error("load without dispatch");

endmodule

### hw/rtl/amdq_dp.sv
module amdq_dp #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16,
    parameter int AW           = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  amdq_pkg::t_in_item           i_item,
    input  logic                         i_cfg_valid,
    input  logic [amdq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [amdq_pkg::VCNT_W-1:0]  i_cfg_data,
    input  amdq_pkg::t_dp_cmd            i_cmd,
    input  logic [AW-1:0]                i_idx,
    output amdq_pkg::t_dp_stat           o_stat,
    // memory port
    output logic                         o_we,
    output logic [AW-1:0]                o_waddr,
    output logic [WEIGHT_BITS-1:0]       o_wdata,
    output logic                         o_re,
    output logic [AW-1:0]                o_raddr_a,
    output logic [AW-1:0]                o_raddr_b,
    input  logic [WEIGHT_BITS-1:0]       i_rdata_a,
    input  logic [WEIGHT_BITS-1:0]       i_rdata_b,
    // results
    output logic                         o_strobe,
    output amdq_pkg::t_out_item          o_result
);
    import amdq_pkg::*;

    localparam int VB  = AW / 2;
    localparam int NZW = $clog2(MAX_VERTICES * MAX_VERTICES + 1);
    localparam int DW  = $clog2(MAX_VERTICES + 1);

    // configuration
    logic              r_directed;
    logic [VCNT_W-1:0] r_vcount;
    // captured item
    logic              r_cmd;
    logic [VTX_W-1:0]  r_u, r_v;
    logic signed [WGT_W-1:0] r_weight;
    // counters
    logic [NZW-1:0]    r_nz_total;
    logic              r_chk;
    logic [VB-1:0]     r_jd;
    logic [DW-1:0]     r_od, r_id;
    logic [NB_W-1:0]   r_nb;
    logic              r_out_vld;
    t_out_item         r_out;

    logic [VCNT_W-1:0]      lim;
    logic [VB-1:0]          ua, va, j;
    logic [WEIGHT_BITS-1:0] w;
    logic                   w_nz, old_nz;
    logic [NZW-1:0]         edges;

    always_comb begin
        lim = (r_vcount > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : r_vcount;
        ua  = VB'(r_u);
        va  = VB'(r_v);
        j   = i_idx[VB-1:0];
        w   = WEIGHT_BITS'(r_weight);
        w_nz = |w;
        old_nz = i_cmd.wr_fwd ? |i_rdata_a : |i_rdata_b;
        edges  = r_directed ? r_nz_total : (r_nz_total >> 1);

        o_stat.is_query  = (r_cmd == CMD_QUERY);
        o_stat.query_ok  = ({1'b0, r_u} < lim);
        o_stat.add_ok    = ({1'b0, r_u} < lim) && ({1'b0, r_v} < lim);
        o_stat.mirror    = !r_directed && (r_u != r_v);
        o_stat.scan_last = ((7'(j) + 7'd1) == 7'(lim));

        o_we    = i_cmd.clr_we | i_cmd.wr_fwd | i_cmd.wr_rev;
        o_waddr = i_cmd.clr_we ? i_idx : (i_cmd.wr_fwd ? {ua, va} : {va, ua});
        o_wdata = i_cmd.clr_we ? '0 : w;
        o_re      = i_cmd.add_rd | i_cmd.scan_rd;
        o_raddr_a = i_cmd.add_rd ? {ua, va} : {ua, j};
        o_raddr_b = i_cmd.add_rd ? {va, ua} : {j, ua};
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_directed <= 1'b0;
            r_vcount   <= VCOUNT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_DIRECTED) begin
                r_directed <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_VCOUNT) begin
                r_vcount <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_item.command;
            r_u      <= i_item.from_vertex;
            r_v      <= i_item.to_vertex;
            r_weight <= i_item.edge_weight;
        end
        r_jd <= j;
    end

    // nonzero entry count over the whole store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz_total <= '0;
        end else if (i_cmd.wr_fwd || i_cmd.wr_rev) begin
            if (old_nz && !w_nz) begin
                r_nz_total <= r_nz_total - NZW'(1);
            end else if (!old_nz && w_nz) begin
                r_nz_total <= r_nz_total + NZW'(1);
            end
        end
    end

    // scan pipeline and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk     <= 1'b0;
            r_od      <= '0;
            r_id      <= '0;
            r_nb      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_chk     <= i_cmd.scan_rd;
            r_out_vld <= 1'b0;
            if (i_cmd.load) begin
                r_od <= '0;
                r_id <= '0;
                r_nb <= '0;
            end else if (r_chk) begin
                if (|i_rdata_a) begin
                    r_od <= r_od + DW'(1);
                    if (r_nb < NB_W'(MAX_RESULTS - 1)) begin
                        r_nb      <= r_nb + NB_W'(1);
                        r_out_vld <= 1'b1;
                    end
                end
                if (|i_rdata_b) begin
                    r_id <= r_id + DW'(1);
                end
            end
            if (i_cmd.sum) begin
                r_out_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_out.item_kind  <= KIND_SUMMARY;
            r_out.neighbor   <= '0;
            r_out.out_degree <= o_stat.query_ok ? DEG_W'(r_od) : '0;
            r_out.in_degree  <= o_stat.query_ok ? DEG_W'(r_id) : '0;
            r_out.edge_total <= (32'(edges) > 32'(ET_MAX)) ? ET_W'(ET_MAX) : ET_W'(edges);
            r_out.bad_vertex <= !o_stat.query_ok;
            r_out.last_item  <= 1'b1;
        end else if (r_chk) begin
            r_out.item_kind  <= KIND_NEIGHBOR;
            r_out.neighbor   <= VTX_W'(r_jd);
            r_out.out_degree <= '0;
            r_out.in_degree  <= '0;
            r_out.edge_total <= '0;
            r_out.bad_vertex <= 1'b0;
            r_out.last_item  <= 1'b0;
        end
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    a_summary_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.last_item) |-> $past(i_cmd.sum))
        else $error("summary item without summary command");

    a_nb_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nb <= NB_W'(MAX_RESULTS - 1))
        else $error("neighbor item count past cap");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_rd || r_chk) |-> !o_we)
        else $error("store written during a scan");

endmodule

### hw/rtl/adjacency_matrix_degree_query.sv
// Channel   Direction  Handshake                      Payload
// item      in         i_start & !o_busy              i_item   (t_in_item)
// result    out        o_strobe, one cycle, no stall  o_result (t_out_item)
// config    in         i_cfg_valid & o_cfg_ready      i_cfg_index, i_cfg_data
//
// Steps from one accepted item to the next possible accept: add = accept,
// dispatch, read old, write, write mirror (no mirror write when not mirrored);
// rejected add = accept, dispatch. Query = accept, dispatch, a scan that reads
// one row entry and one column entry per cycle from the two read ports of the
// weight store, flush, summary; rejected query = accept, dispatch, summary.
// Reset: synchronous, active low; then a clearing sweep writes zero to all
// 2^(2*ceil(log2(MAX_VERTICES))) entries (1024 entries at 32 vertices) with
// o_busy high. Config writes are taken at any time (o_cfg_ready is tied high).
// Results cannot be stalled: each is on o_result for exactly one cycle.
module adjacency_matrix_degree_query #(
    parameter int MAX_VERTICES = amdq_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = amdq_pkg::WEIGHT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item channel
    input  logic                           i_start,
    output logic                           o_busy,
    input  amdq_pkg::t_in_item             i_item,
    // result channel
    output logic                           o_strobe,
    output amdq_pkg::t_out_item            o_result,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [amdq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [amdq_pkg::VCNT_W-1:0]    i_cfg_data
);
    import amdq_pkg::*;

    // Store addressed as {row, column}, each ceil(log2(MAX_VERTICES)) bits
    localparam int VB    = $clog2(MAX_VERTICES);
    localparam int AW    = 2 * VB;
    localparam int DEPTH = 1 << AW;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic [AW-1:0] idx;

    logic                   we, re;
    logic [AW-1:0]          waddr, raddr_a, raddr_b;
    logic [WEIGHT_BITS-1:0] wdata, rdata_a, rdata_b;

    assign o_cfg_ready = 1'b1;

    // Sequencer: clearing sweep, add read-modify-write, row/column scan
    amdq_ctrl #(
        .AW (AW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_idx   (idx)
    );

    // Item capture, config, edge count, degree counters, result register
    amdq_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS),
        .AW           (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .o_stat      (stat),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // Weight store; port A reads the row entry, port B the column entry
    amdq_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (re),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

endmodule

### test/tb_adjacency_matrix_degree_query.sv
module tb_adjacency_matrix_degree_query;
    import amdq_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 8;
    // Slowest run: clearing sweep plus ~480 items, each at most one full query,
    // plus sender gaps and drains; take a limit several times that.
    localparam int CYCLE_LIMIT  = 300000;
    // An add gives no result, so it can still run after the last result has come;
    // wait this long before touching the configuration.
    localparam int ADD_SETTLE   = 10;
    localparam int END_SETTLE   = 60;
    localparam int MAX_REPORTS  = 40;
    localparam int NVTX         = MAX_VERTICES_DEF;
    localparam int DEG_MAX      = (1 << DEG_W) - 1;

    // DUT ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_in_item              i_item;
    logic                  o_strobe;
    t_out_item             o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [VCNT_W-1:0]     i_cfg_data;

    // Shadow graph: weights, nonzero entry count and register copies
    logic [WGT_W-1:0]      weight_store [NVTX][NVTX];
    int unsigned           nonzero_count;
    logic                  is_directed;
    logic [VCNT_W-1:0]     vertex_count_cfg;

    // Results still owed by the DUT, oldest first
    t_out_item             expected_results [$];

    int unsigned           mismatch_count;
    int unsigned           cycle_count;
    int unsigned           burst_left;

    adjacency_matrix_degree_query u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog: a hang or a lost result ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Graph predictor
    // ------------------------------------------------------------------

    // vertex_count above MAX_VERTICES behaves as MAX_VERTICES
    function automatic int unsigned vertex_limit();
        return (vertex_count_cfg > NVTX) ? NVTX : vertex_count_cfg;
    endfunction

    // Append one owed result at the tail of the queue
    function automatic void owe_result(t_out_item res);
        expected_results.insert(expected_results.size(), res);
    endfunction

    // Store one entry and keep the count of nonzero entries in step
    function automatic void store_weight(logic [VTX_W-1:0] r, logic [VTX_W-1:0] c,
                                         logic [WGT_W-1:0] w);
        logic was_edge;
        was_edge = (weight_store[r][c] != '0);
        weight_store[r][c] = w;
        if (was_edge && w == '0)
            nonzero_count--;
        else if (!was_edge && w != '0)
            nonzero_count++;
    endfunction

    // Apply one accepted item to the shadow graph and queue what it must produce
    function automatic void apply_graph_item(t_in_item it);
        int unsigned lim;
        int unsigned edges;
        int unsigned out_deg;
        int unsigned in_deg;
        int unsigned streamed;
        t_out_item   res;
        lim      = vertex_limit();
        edges    = is_directed ? nonzero_count : nonzero_count / 2;
        out_deg  = 0;
        in_deg   = 0;
        streamed = 0;
        if (edges > ET_MAX)
            edges = ET_MAX;

        if (it.command == CMD_ADD) begin
            // either end out of range: silently dropped
            if (it.from_vertex >= lim || it.to_vertex >= lim)
                return;
            store_weight(it.from_vertex, it.to_vertex, it.edge_weight);
            // undirected mirror; a self-loop lands on the same entry
            if (!is_directed)
                store_weight(it.to_vertex, it.from_vertex, it.edge_weight);
            return;
        end

        res = '0;
        if (it.from_vertex >= lim) begin
            // rejected query: lone summary, degrees zero, edge total still valid
            res.item_kind  = KIND_SUMMARY;
            res.edge_total = edges[ET_W-1:0];
            res.bad_vertex = 1'b1;
            res.last_item  = 1'b1;
            owe_result(res);
            return;
        end

        for (int unsigned j = 0; j < lim; j++) begin
            if (weight_store[it.from_vertex][j] != '0) begin
                out_deg++;
                if (streamed < MAX_RESULTS - 1) begin
                    res           = '0;
                    res.item_kind = KIND_NEIGHBOR;
                    res.neighbor  = j[VTX_W-1:0];
                    owe_result(res);
                    streamed++;
                end
            end
            if (weight_store[j][it.from_vertex] != '0)
                in_deg++;
        end

        res            = '0;
        res.item_kind  = KIND_SUMMARY;
        res.out_degree = (out_deg > DEG_MAX) ? DEG_W'(DEG_MAX) : out_deg[DEG_W-1:0];
        res.in_degree  = (in_deg > DEG_MAX) ? DEG_W'(DEG_MAX) : in_deg[DEG_W-1:0];
        res.edge_total = edges[ET_W-1:0];
        res.last_item  = 1'b1;
        owe_result(res);
    endfunction

    // ------------------------------------------------------------------
    // Result checker: results stand for one cycle, so look once per cycle
    // at the negative edge where everything has settled.
    // ------------------------------------------------------------------

    function automatic void check_field(string name, int unsigned want,
                                        int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endfunction

    always @(negedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n === 1'b1 && o_strobe !== 1'b0) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_result);
            end else begin
                want = expected_results.pop_front();
                check_field("item_kind",  32'(want.item_kind),
                            32'(o_result.item_kind));
                check_field("neighbor",   32'(want.neighbor),
                            32'(o_result.neighbor));
                check_field("out_degree", 32'(want.out_degree),
                            32'(o_result.out_degree));
                check_field("in_degree",  32'(want.in_degree),
                            32'(o_result.in_degree));
                check_field("edge_total", 32'(want.edge_total),
                            32'(o_result.edge_total));
                check_field("bad_vertex", 32'(want.bad_vertex),
                            32'(o_result.bad_vertex));
                check_field("last_item",  32'(want.last_item),
                            32'(o_result.last_item));
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Everything is driven with NBAs right after a rising edge.
    // ------------------------------------------------------------------

    // Present one item and hold it until the DUT takes it; i_start is left
    // high so the next item can follow as soon as the DUT is idle again.
    task automatic send_item(input t_in_item it);
        i_item  <= it;
        i_start <= 1'b1;
        do @(negedge i_clk); while (o_busy !== 1'b0);
        @(posedge i_clk);
        apply_graph_item(it);
    endtask

    task automatic add_edge(input int unsigned u, input int unsigned v,
                            input logic [WGT_W-1:0] w);
        t_in_item it;
        it.command     = CMD_ADD;
        it.from_vertex = u[VTX_W-1:0];
        it.to_vertex   = v[VTX_W-1:0];
        it.edge_weight = w;
        send_item(it);
    endtask

    // to_vertex and weight are don't-cares for a query, so randomize them
    task automatic query_vertex(input int unsigned u);
        t_in_item it;
        it.command     = CMD_QUERY;
        it.from_vertex = u[VTX_W-1:0];
        it.to_vertex   = VTX_W'($urandom_range(0, NVTX - 1));
        it.edge_weight = WGT_W'($urandom);
        send_item(it);
    endtask

    task automatic idle_cycles(input int unsigned n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Sender pacing: random bursts, random gaps, now and then a long burst
    task automatic pace_sender();
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 7) == 0)
                idle_cycles($urandom_range(10, 40));
            else
                idle_cycles($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Stop sending and wait for every owed result, then let a trailing add
    // finish and the DUT go idle.
    task automatic drain_results();
        i_start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (ADD_SETTLE) @(posedge i_clk);
        do @(negedge i_clk); while (o_busy !== 1'b0);
        @(posedge i_clk);
    endtask

    // Write both registers back to back; valid stays up between the two.
    // Only bit 0 of the direction word matters, the rest is noise.
    task automatic apply_config(input logic [VCNT_W-1:0] dir_word,
                                input logic [VCNT_W-1:0] count);
        i_cfg_index <= CFG_DIRECTED;
        i_cfg_data  <= dir_word;
        i_cfg_valid <= 1'b1;
        do @(negedge i_clk); while (o_cfg_ready !== 1'b1);
        @(posedge i_clk);
        is_directed = dir_word[0];
        i_cfg_index <= CFG_VCOUNT;
        i_cfg_data  <= count;
        do @(negedge i_clk); while (o_cfg_ready !== 1'b1);
        @(posedge i_clk);
        vertex_count_cfg = count;
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly in-range vertices so edges build up; some out-of-range noise
    function automatic t_in_item random_graph_item();
        t_in_item    it;
        int unsigned lim;
        lim        = vertex_limit();
        it.command = ($urandom_range(0, 99) < 30) ? CMD_QUERY : CMD_ADD;
        if (lim != 0 && $urandom_range(0, 9) != 0) begin
            it.from_vertex = VTX_W'($urandom_range(0, lim - 1));
            it.to_vertex   = VTX_W'($urandom_range(0, lim - 1));
        end else begin
            it.from_vertex = VTX_W'($urandom_range(0, NVTX - 1));
            it.to_vertex   = VTX_W'($urandom_range(0, NVTX - 1));
        end
        case ($urandom_range(0, 9))
            0: begin
                it.edge_weight = '0;
            end
            1: begin
                it.edge_weight = 16'sh7FFF;
            end
            2: begin
                it.edge_weight = 16'sh8000;
            end
            3: begin
                it.edge_weight = '1;
            end
            default: begin
                it.edge_weight = WGT_W'($urandom);
                if (it.edge_weight == '0)
                    it.edge_weight = 16'sd1;
            end
        endcase
        return it;
    endfunction

    task automatic random_traffic(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            send_item(random_graph_item());
            pace_sender();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fresh graph after reset: undirected, 32 vertices, nothing stored
    task automatic test_empty_graph();
        query_vertex(0);
        query_vertex(NVTX - 1);
    endtask

    // Directed: weight extremes, self-loop, overwrite, erase by zero weight
    task automatic test_directed_edges();
        drain_results();
        apply_config(6'd1, 6'd32);
        add_edge(0, 31, 16'sh7FFF);
        add_edge(31, 0, 16'sh8000);
        add_edge(5, 5, 16'shFFFF);
        add_edge(5, 7, 16'sd1);
        add_edge(5, 7, 16'sh1234);
        query_vertex(5);
        add_edge(0, 31, 16'sd0);
        query_vertex(31);
        query_vertex(0);
    endtask

    // Undirected: mirrored writes, overwrite from the other side, self-loop
    // counted once in the nonzero total before it is halved
    task automatic test_undirected_edges();
        drain_results();
        apply_config(6'b111110, 6'd32);
        add_edge(3, 9, 16'shFFFE);
        add_edge(9, 3, 16'sd77);
        add_edge(4, 4, 16'sd5);
        query_vertex(9);
        query_vertex(4);
        add_edge(3, 9, 16'sd0);
        query_vertex(3);
    endtask

    // Vertex limit: smallest, zero (rejects all), above the maximum, and a
    // shrink that hides stored entries from scans but not from the total
    task automatic test_vertex_limit();
        drain_results();
        apply_config(6'd1, 6'd1);
        add_edge(0, 0, 16'sd9);
        add_edge(0, 1, 16'sd5);
        query_vertex(0);
        query_vertex(1);
        drain_results();
        apply_config(6'd1, 6'd0);
        add_edge(0, 0, 16'sd0);
        query_vertex(0);
        drain_results();
        apply_config(6'd1, 6'd63);
        add_edge(31, 2, 16'sd3);
        query_vertex(31);
        drain_results();
        apply_config(6'd1, 6'd4);
        query_vertex(3);
    endtask

    task automatic test_random_undirected();
        drain_results();
        apply_config(6'd0, 6'd32);
        random_traffic(120);
    endtask

    // Includes a pause mid-stream until every result is back
    task automatic test_random_directed();
        drain_results();
        apply_config(6'd1, 6'd32);
        random_traffic(60);
        drain_results();
        random_traffic(60);
    endtask

    // Small graphs, oversized count, and the reject-everything setting
    task automatic test_random_limits();
        drain_results();
        apply_config(VCNT_W'($urandom_range(0, 63)), VCNT_W'($urandom_range(1, 6)));
        random_traffic(60);
        drain_results();
        apply_config(6'd0, VCNT_W'($urandom_range(33, 63)));
        random_traffic(40);
        drain_results();
        apply_config(6'd1, 6'd0);
        random_traffic(10);
    endtask

    // Fill the whole row and column of the last vertex: 32 neighbors plus
    // summary, the longest query; then flip direction with the store kept
    task automatic test_full_row();
        drain_results();
        apply_config(6'd1, 6'd32);
        for (int unsigned j = 0; j < NVTX; j++) begin
            add_edge(NVTX - 1, j, WGT_W'(($urandom & 16'h7FFF) | 16'h0100));
            pace_sender();
            add_edge(j, NVTX - 1, WGT_W'($urandom | 16'h8000));
            pace_sender();
        end
        query_vertex(NVTX - 1);
        drain_results();
        apply_config(6'd0, 6'd32);
        query_vertex(NVTX - 1);
        random_traffic(40);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        i_start          = 1'b0;
        i_item           = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_DIRECTED;
        i_cfg_data       = '0;
        mismatch_count   = 0;
        cycle_count      = 0;
        burst_left       = 0;
        nonzero_count    = 0;
        is_directed      = 1'b0;
        vertex_count_cfg = VCOUNT_RST;
        for (int r = 0; r < NVTX; r++)
            for (int c = 0; c < NVTX; c++)
                weight_store[r][c] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // clearing sweep runs with busy high
        do @(negedge i_clk); while (o_busy !== 1'b0);
        @(posedge i_clk);

        test_empty_graph();
        test_directed_edges();
        test_undirected_edges();
        test_vertex_limit();
        test_random_undirected();
        test_random_directed();
        test_random_limits();
        test_full_row();

        i_start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
hw/rtl/amdq_pkg.sv
hw/rtl/amdq_ram.sv
hw/rtl/amdq_ctrl.sv
hw/rtl/amdq_dp.sv
hw/rtl/adjacency_matrix_degree_query.sv
test/tb_adjacency_matrix_degree_query.sv
